// ----- hw/rtl/bzr_pkg.sv -----
// Shared types and fixed constants of the buzzer beep pattern sequencer.
`default_nettype none
package bzr_pkg;

	// Event codes carried in the action field
	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_SET    = 2'd1;
	localparam logic [1:0] ACT_KEY    = 2'd2;
	localparam logic [1:0] ACT_REMOTE = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KEYPAD_EN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REMOTE_EN = 1'd1;

	// Timer constants
	localparam logic [11:0] START_DELAY    = 12'd10;
	localparam logic [4:0]  KEY_BEEP_TICKS = 5'd16;
	localparam logic [3:0]  DUR_COUNT      = 4'd10;

	// Sequencer state
	typedef struct packed {
		logic        alarm_on;
		logic [3:0]  pattern_step;
		logic [11:0] pattern_countdown;
		logic        pattern_armed;
		logic [4:0]  key_countdown;
		logic        key_armed;
		logic        key_beep_active;
		logic        requested_level;
		logic        pin_level;
	} bzr_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/bzr_ifs.sv -----
// Valid/ready channel interfaces for the event input and the status output.
`default_nettype none
interface bzr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       set_value;

	modport source(output valid, output action, output set_value, input ready);
	modport sink(input valid, input action, input set_value, output ready);
endinterface

interface bzr_out_if;
	logic valid;
	logic ready;
	logic buzzer_pin;
	logic pattern_running;
	logic key_beep_running;

	modport source(output valid, output buzzer_pin, output pattern_running,
		output key_beep_running, input ready);
	modport sink(input valid, input buzzer_pin, input pattern_running,
		input key_beep_running, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bzr_step.sv -----
// Next-state logic: applies one event to the sequencer state.
`default_nettype none
module bzr_step import bzr_pkg::*; #(
	parameter int TICKS_PER_SECOND = 100,
	parameter int PATTERN_STEPS    = 10
) (
	input  wire bzr_state_t cur,
	input  wire logic [1:0] action,
	input  wire logic       set_value,
	input  wire logic       keypad_en,
	input  wire logic       remote_en,
	output bzr_state_t      nx
);

	// Step durations in ticks
	localparam logic [11:0] D_LONG  = 12'(3 * TICKS_PER_SECOND / 10);
	localparam logic [11:0] D_MID   = 12'(15 * TICKS_PER_SECOND / 100);
	localparam logic [11:0] D_SHORT = 12'(1 * TICKS_PER_SECOND / 10);
	localparam logic [11:0] D_TENTH = 12'(10 * TICKS_PER_SECOND / 100);
	localparam logic [11:0] D_PAUSE = 12'(3 * TICKS_PER_SECOND);
	localparam logic [4:0]  STEPS   = 5'(PATTERN_STEPS);

	function automatic logic [11:0] dur_of(input logic [3:0] idx);
		logic [11:0] d;
		case (idx)
			4'd0, 4'd2, 4'd4: d = D_LONG;
			4'd1, 4'd3, 4'd5: d = D_MID;
			4'd6, 4'd8:       d = D_SHORT;
			4'd7:             d = D_TENTH;
			4'd9:             d = D_PAUSE;
			default:          d = D_LONG;
		endcase
		return d;
	endfunction

	logic [3:0]  dur_idx;
	logic [4:0]  step_inc;
	logic [3:0]  step_nx;
	logic        lvl;
	logic        do_key;

	// Table index and wrapped step, from the step before this event
	assign dur_idx  = (cur.pattern_step >= DUR_COUNT) ?
		(cur.pattern_step - DUR_COUNT) : cur.pattern_step;
	assign step_inc = {1'b0, cur.pattern_step} + 5'd1;
	assign step_nx  = ({1'b0, step_inc[3:0]} >= STEPS) ? 4'd0 : step_inc[3:0];
	assign lvl      = ~cur.pattern_step[0];

	always_comb begin
		nx     = cur;
		do_key = 1'b0;
		case (action)
			ACT_TICK: begin
				// key beep timer goes first
				if (nx.key_armed) begin
					if (nx.key_countdown <= 5'd1) begin
						nx.key_armed       = 1'b0;
						nx.key_countdown   = 5'd0;
						nx.key_beep_active = 1'b0;
						nx.pin_level       = 1'b0;
					end else begin
						nx.key_countdown = nx.key_countdown - 5'd1;
					end
				end
				// then the pattern timer
				if (nx.pattern_armed) begin
					if (nx.pattern_countdown <= 12'd1) begin
						if (nx.alarm_on) begin
							nx.requested_level   = lvl;
							if (lvl || !nx.key_beep_active)
								nx.pin_level = lvl;
							nx.pattern_countdown = dur_of(dur_idx);
							nx.pattern_armed     = 1'b1;
							nx.pattern_step      = step_nx;
						end else begin
							nx.pattern_countdown = 12'd0;
							nx.pattern_armed     = 1'b0;
							nx.pattern_step      = 4'd0;
							nx.requested_level   = 1'b0;
							if (!nx.key_beep_active)
								nx.pin_level = 1'b0;
						end
					end else begin
						nx.pattern_countdown = nx.pattern_countdown - 12'd1;
					end
				end
			end
			ACT_SET: begin
				if (set_value) begin
					if (!nx.alarm_on) begin
						nx.alarm_on          = 1'b1;
						nx.pattern_countdown = START_DELAY;
						nx.pattern_armed     = 1'b1;
					end
				end else begin
					nx.alarm_on = 1'b0;
				end
			end
			ACT_KEY:    do_key = 1'b1;
			ACT_REMOTE: do_key = remote_en;
			default:    do_key = 1'b0;
		endcase

		// key beep only while the requested level is low
		if (do_key && keypad_en && !nx.requested_level) begin
			nx.pin_level       = 1'b1;
			nx.key_countdown   = KEY_BEEP_TICKS;
			nx.key_armed       = 1'b1;
			nx.key_beep_active = 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/buzzer_beep_pattern_sequencer.sv -----
// Buzzer beep pattern sequencer top level: input stage, state and result register.
// Path: a beat accepted into the input register has its result written to the result
// register when stage 1 advances, and the result register then offers it on out_ch.
// Throughput: one beat per cycle; the input register and the result register
// both advance together whenever the result register is free or being taken.
// Reset: arst_n clears the state, both enables and the valid flags at once.
`default_nettype none
module buzzer_beep_pattern_sequencer import bzr_pkg::*; #(
	parameter int TICKS_PER_SECOND = 100,
	parameter int PATTERN_STEPS    = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	bzr_in_if.sink                    in_ch,
	bzr_out_if.source                 out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic                 cfg_wdata
);

	logic       keypad_en_q;
	logic       remote_en_q;
	logic       vld_s1;
	logic [1:0] action_s1;
	logic       set_value_s1;
	logic       out_vld_q;
	logic       advance;
	bzr_state_t st_q;
	bzr_state_t st_nx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keypad_en_q <= 1'b0;
			remote_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEYPAD_EN: keypad_en_q <= cfg_wdata;
				REG_REMOTE_EN: remote_en_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// Stage 1 moves on when the result register can take a new beat
	assign advance     = vld_s1 && (!out_vld_q || out_ch.ready);
	assign in_ch.ready = !vld_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1    <= in_ch.action;
			set_value_s1 <= in_ch.set_value;
		end
	end

	bzr_step #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.PATTERN_STEPS   (PATTERN_STEPS)
	) u_step (
		.cur      (st_q),
		.action   (action_s1),
		.set_value(set_value_s1),
		.keypad_en(keypad_en_q),
		.remote_en(remote_en_q),
		.nx       (st_nx)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_ch.buzzer_pin       <= st_nx.pin_level;
			out_ch.pattern_running  <= st_nx.alarm_on;
			out_ch.key_beep_running <= st_nx.key_beep_active;
		end
	end

	assign out_ch.valid = out_vld_q;

	// Checks
	a_beep_armed: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.key_beep_active |-> (st_q.key_armed && st_q.key_countdown != 5'd0))
		else $error("key beep active without a running key timer");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, st_q.pattern_step} < 5'(PATTERN_STEPS))
		else $error("pattern step out of range");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_vld_q)
		else $error("result register not loaded after advance");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_ch.buzzer_pin == st_q.pin_level
			&& out_ch.pattern_running == st_q.alarm_on
			&& out_ch.key_beep_running == st_q.key_beep_active))
		else $error("offered result differs from sequencer state");

endmodule
`default_nettype wire
